[sv/ecdsa_pkg.sv]
// Package for the ECDSA sign/verify engine: word type, payload structs,
// register indexes, status codes and the modular add/subtract helpers.
// No dependencies.
`default_nettype none

package ecdsa_pkg;

  localparam int WORD_BITS = 31;
  localparam int CNT_BITS  = $clog2(WORD_BITS);
  localparam int CFG_IDX_BITS = 3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic  req_type;
    word_t digest;
    word_t nonce;
    word_t sig_r_in;
    word_t sig_s_in;
  } in_t;

  typedef struct packed {
    word_t      sig_r;
    word_t      sig_s;
    logic [1:0] status;
  } out_t;

  // request types
  localparam logic REQ_SIGN   = 1'b0;
  localparam logic REQ_VERIFY = 1'b1;

  // status codes
  localparam logic [1:0] ST_SIGNED   = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_VALID    = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_PRIME = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GROUP_ORDER = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GEN_X       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GEN_Y       = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PRIVATE_KEY = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUB_X       = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PUB_Y       = 3'd7;

  // arithmetic unit operations
  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_RED = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
    word_t   a;
    word_t   b;
    word_t   m;
  } alu_req_t;

  // operands already below m; m == 0 gives 0
  function automatic word_t addm(input word_t a, input word_t b, input word_t m);
    word_t d;
    d = m - b;
    if (m == '0) return '0;
    return (a >= d) ? (a - d) : (a + b);
  endfunction

  function automatic word_t subm(input word_t a, input word_t b, input word_t m);
    if (m == '0) return '0;
    return (a >= b) ? (a - b) : (a + (m - b));
  endfunction

endpackage

`default_nettype wire

[sv/ecdsa_mod_alu.sv]
// Bit-serial modular arithmetic unit: shift-and-add multiply and
// restoring reduction, one operand bit per cycle. Uses ecdsa_pkg.
`default_nettype none

module ecdsa_mod_alu (
  input  logic                clk,
  input  logic                rst_n,
  input  ecdsa_pkg::alu_req_t req,
  output logic                done,
  output ecdsa_pkg::word_t    res
);

  logic                           busy_r;
  logic                           done_r;
  logic [ecdsa_pkg::CNT_BITS-1:0] cnt_r;
  ecdsa_pkg::alu_op_t             op_r;
  ecdsa_pkg::word_t               m_r;
  ecdsa_pkg::word_t               acc_r;
  ecdsa_pkg::word_t               x_r;   // doubled operand, or remainder
  ecdsa_pkg::word_t               y_r;   // multiplier bits, or dividend bits

  logic [ecdsa_pkg::WORD_BITS:0]  rem_ext;
  logic [ecdsa_pkg::WORD_BITS:0]  rem_sub;

  assign rem_ext = {x_r, y_r[ecdsa_pkg::WORD_BITS-1]};
  assign rem_sub = rem_ext - {1'b0, m_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        op_r   <= req.op;
        m_r    <= req.m;
        acc_r  <= '0;
        if (req.op == ecdsa_pkg::ALU_MUL) begin
          x_r <= req.a;
          y_r <= req.b;
        end else begin
          x_r <= '0;
          y_r <= req.a;
        end
      end else if (busy_r) begin
        unique case (op_r)
          ecdsa_pkg::ALU_MUL: begin
            if (y_r[0]) acc_r <= ecdsa_pkg::addm(acc_r, x_r, m_r);
            x_r <= ecdsa_pkg::addm(x_r, x_r, m_r);
            y_r <= y_r >> 1;
          end
          ecdsa_pkg::ALU_RED: begin
            if (rem_ext >= {1'b0, m_r}) x_r <= rem_sub[ecdsa_pkg::WORD_BITS-1:0];
            else                         x_r <= rem_ext[ecdsa_pkg::WORD_BITS-1:0];
            y_r <= y_r << 1;
          end
          default: ;
        endcase
        if (cnt_r == ecdsa_pkg::CNT_BITS'(ecdsa_pkg::WORD_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign res  = (m_r == '0) ? '0 : ((op_r == ecdsa_pkg::ALU_MUL) ? acc_r : x_r);

endmodule

`default_nettype wire

[sv/ecdsa_sign_verify_engine_unit.sv]
// ECDSA sign/verify engine top level; uses ecdsa_pkg and ecdsa_mod_alu.
// Each modular product runs on one shared bit-serial unit (W = 31); a point add is dominated
// by its Fermat inverse (up to 2W products). Sign: one scalar multiply of up to 2W adds;
// verify: two scalar multiplies plus an add.
// Throughput: one transaction at a time; the next is taken once the result sits in the
// output register. Synchronous reset loads the register reset values and returns to idle.
`default_nettype none

module ecdsa_sign_verify_engine_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  ecdsa_pkg::in_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output ecdsa_pkg::out_t                        out_data,
  input  logic                                   cfg_we,
  input  logic [ecdsa_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  ecdsa_pkg::word_t                       cfg_data
);

  localparam int W  = ecdsa_pkg::WORD_BITS;
  localparam int NS = 37;

  // Sequencer. Subroutines (point multiply, point add, inverse, unit wait)
  // each keep their own return state.
  typedef enum logic [NS-1:0] {
    S_IDLE    = 37'd1 << 0,
    S_PRE     = 37'd1 << 1,
    S_PRE_D   = 37'd1 << 2,
    S_DISP    = 37'd1 << 3,
    S_MW      = 37'd1 << 4,
    S_INV_ENT = 37'd1 << 5,
    S_INV_LP  = 37'd1 << 6,
    S_INV_ACC = 37'd1 << 7,
    S_INV_SQ  = 37'd1 << 8,
    S_INV_SQD = 37'd1 << 9,
    S_PM_ENT  = 37'd1 << 10,
    S_PM_DBL  = 37'd1 << 11,
    S_PM_DBLD = 37'd1 << 12,
    S_PM_NXT  = 37'd1 << 13,
    S_PA_ENT  = 37'd1 << 14,
    S_PA_T1   = 37'd1 << 15,
    S_PA_T2   = 37'd1 << 16,
    S_PA_T3   = 37'd1 << 17,
    S_PA_DEN  = 37'd1 << 18,
    S_PA_LAM  = 37'd1 << 19,
    S_PA_L2   = 37'd1 << 20,
    S_PA_X    = 37'd1 << 21,
    S_PA_Y1   = 37'd1 << 22,
    S_PA_Y2   = 37'd1 << 23,
    S_VF_U1   = 37'd1 << 24,
    S_VF_U2   = 37'd1 << 25,
    S_VF_U3   = 37'd1 << 26,
    S_VF_S    = 37'd1 << 27,
    S_VF_ADD  = 37'd1 << 28,
    S_VF_CHK  = 37'd1 << 29,
    S_VF_CMP  = 37'd1 << 30,
    S_SG_R    = 37'd1 << 31,
    S_SG_R2   = 37'd1 << 32,
    S_SG_T    = 37'd1 << 33,
    S_SG_S    = 37'd1 << 34,
    S_SG_S2   = 37'd1 << 35,
    S_FIN     = 37'd1 << 36
  } state_t;

  // operand pre-reduction list
  localparam logic [3:0] PRE_GX = 4'd0;
  localparam logic [3:0] PRE_GY = 4'd1;
  localparam logic [3:0] PRE_A  = 4'd2;
  localparam logic [3:0] PRE_C3 = 4'd3;
  localparam logic [3:0] PRE_C2 = 4'd4;
  localparam logic [3:0] PRE_QX = 4'd5;
  localparam logic [3:0] PRE_QY = 4'd6;
  localparam logic [3:0] PRE_H  = 4'd7;
  localparam logic [3:0] PRE_D  = 4'd8;
  localparam logic [3:0] PRE_K  = 4'd9;

  // configuration registers
  ecdsa_pkg::word_t cfg_p_r, cfg_a_r, cfg_q_r, cfg_gx_r, cfg_gy_r;
  ecdsa_pkg::word_t cfg_d_r, cfg_qx_r, cfg_qy_r;

  state_t state_r, mw_ret_r, inv_ret_r, pa_ret_r, pm_ret_r;

  ecdsa_pkg::in_t   req_r;
  logic [3:0]       pre_idx_r;

  // reduced operands
  ecdsa_pkg::word_t gx_r, gy_r, ap_r, c3_r, c2_r, qx_r, qy_r, hq_r, dq_r, kq_r;

  // point registers: accumulator R, operands A and C, base B, saved S
  ecdsa_pkg::word_t rx_r, ry_r, ax_r, ay_r, cx_r, cy_r, bx_r, by_r, sx_r, sy_r;
  logic             rinf_r, ainf_r, cinf_r, sinf_r;

  ecdsa_pkg::word_t num_r, den_r, lam_r, x3_r, t_r, u1_r, u2_r;
  ecdsa_pkg::word_t sc_r;
  logic [ecdsa_pkg::CNT_BITS-1:0] pm_cnt_r, inv_cnt_r;

  // inverse
  ecdsa_pkg::word_t inv_a_r, inv_m_r, inv_acc_r, inv_b_r, inv_e_r;

  // signature results
  ecdsa_pkg::word_t sr_r, ss_r;
  logic [1:0]       st_r;

  logic             out_valid_r;
  ecdsa_pkg::out_t  out_q_r;

  // arithmetic unit request
  logic               mu_start_r;
  ecdsa_pkg::alu_op_t mu_op_r;
  ecdsa_pkg::word_t   mu_a_r, mu_b_r, mu_m_r;
  ecdsa_pkg::alu_req_t mu_req;
  logic               mu_done;
  ecdsa_pkg::word_t   mu_res;

  assign mu_req = '{start: mu_start_r, op: mu_op_r, a: mu_a_r, b: mu_b_r, m: mu_m_r};

  ecdsa_mod_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mu_req),
    .done  (mu_done),
    .res   (mu_res)
  );

  // pre-reduction source and modulus
  ecdsa_pkg::word_t pre_val, pre_mod;
  always_comb begin
    unique case (pre_idx_r)
      PRE_GX:  pre_val = cfg_gx_r;
      PRE_GY:  pre_val = cfg_gy_r;
      PRE_A:   pre_val = cfg_a_r;
      PRE_C3:  pre_val = W'(3);
      PRE_C2:  pre_val = W'(2);
      PRE_QX:  pre_val = cfg_qx_r;
      PRE_QY:  pre_val = cfg_qy_r;
      PRE_H:   pre_val = req_r.digest;
      PRE_D:   pre_val = cfg_d_r;
      PRE_K:   pre_val = req_r.nonce;
      default: pre_val = '0;
    endcase
    pre_mod = (pre_idx_r >= PRE_H) ? cfg_q_r : cfg_p_r;
  end

  logic sig_in_range;
  assign sig_in_range = (req_r.sig_r_in != '0) && (req_r.sig_r_in < cfg_q_r) &&
                        (req_r.sig_s_in != '0) && (req_r.sig_s_in < cfg_q_r);

  logic pts_differ;
  assign pts_differ = (ax_r != cx_r) || (ay_r != cy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mu_start_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_p_r     <= W'(3);
      cfg_a_r     <= '0;
      cfg_q_r     <= W'(2);
      cfg_gx_r    <= '0;
      cfg_gy_r    <= '0;
      cfg_d_r     <= '0;
      cfg_qx_r    <= '0;
      cfg_qy_r    <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid_r && out_ready && state_r != S_FIN) out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_idx)
          ecdsa_pkg::CFG_FIELD_PRIME: cfg_p_r  <= cfg_data;
          ecdsa_pkg::CFG_CURVE_A:     cfg_a_r  <= cfg_data;
          ecdsa_pkg::CFG_GROUP_ORDER: cfg_q_r  <= cfg_data;
          ecdsa_pkg::CFG_GEN_X:       cfg_gx_r <= cfg_data;
          ecdsa_pkg::CFG_GEN_Y:       cfg_gy_r <= cfg_data;
          ecdsa_pkg::CFG_PRIVATE_KEY: cfg_d_r  <= cfg_data;
          ecdsa_pkg::CFG_PUB_X:       cfg_qx_r <= cfg_data;
          ecdsa_pkg::CFG_PUB_Y:       cfg_qy_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r     <= in_data;
            pre_idx_r <= PRE_GX;
            state_r   <= S_PRE;
          end
        end

        // reduce config values, constants and inputs one at a time
        S_PRE: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_RED;
          mu_a_r     <= pre_val;
          mu_m_r     <= pre_mod;
          mw_ret_r   <= S_PRE_D;
          state_r    <= S_MW;
        end

        S_PRE_D: begin
          unique case (pre_idx_r)
            PRE_GX:  gx_r <= mu_res;
            PRE_GY:  gy_r <= mu_res;
            PRE_A:   ap_r <= mu_res;
            PRE_C3:  c3_r <= mu_res;
            PRE_C2:  c2_r <= mu_res;
            PRE_QX:  qx_r <= mu_res;
            PRE_QY:  qy_r <= mu_res;
            PRE_H:   hq_r <= mu_res;
            PRE_D:   dq_r <= mu_res;
            PRE_K:   kq_r <= mu_res;
            default: ;
          endcase
          if (pre_idx_r == PRE_K) begin
            state_r <= S_DISP;
          end else begin
            pre_idx_r <= pre_idx_r + 4'd1;
            state_r   <= S_PRE;
          end
        end

        S_DISP: begin
          if (req_r.req_type == ecdsa_pkg::REQ_SIGN) begin
            bx_r     <= gx_r;
            by_r     <= gy_r;
            sc_r     <= req_r.nonce;
            pm_ret_r <= S_SG_R;
            state_r  <= S_PM_ENT;
          end else if (!sig_in_range) begin
            st_r    <= ecdsa_pkg::ST_INVALID;
            sr_r    <= '0;
            ss_r    <= '0;
            state_r <= S_FIN;
          end else begin
            inv_a_r   <= req_r.sig_s_in;
            inv_m_r   <= cfg_q_r;
            inv_ret_r <= S_VF_U1;
            state_r   <= S_INV_ENT;
          end
        end

        // wait for the arithmetic unit; the start pulse lasts one cycle
        S_MW: begin
          mu_start_r <= 1'b0;
          if (mu_done) state_r <= mw_ret_r;
        end

        // Fermat inverse: a^(m-2) mod m, LSB-first square-and-multiply
        S_INV_ENT: begin
          inv_b_r   <= inv_a_r;
          inv_e_r   <= inv_m_r - W'(2);
          inv_cnt_r <= '0;
          if (inv_m_r < W'(2) || inv_a_r == '0) begin
            inv_acc_r <= '0;
            state_r   <= inv_ret_r;
          end else begin
            inv_acc_r <= W'(1);
            state_r   <= S_INV_LP;
          end
        end

        S_INV_LP: begin
          if (inv_e_r[0]) begin
            mu_start_r <= 1'b1;
            mu_op_r    <= ecdsa_pkg::ALU_MUL;
            mu_a_r     <= inv_acc_r;
            mu_b_r     <= inv_b_r;
            mu_m_r     <= inv_m_r;
            mw_ret_r   <= S_INV_ACC;
            state_r    <= S_MW;
          end else begin
            state_r <= S_INV_SQ;
          end
        end

        S_INV_ACC: begin
          inv_acc_r <= mu_res;
          state_r   <= S_INV_SQ;
        end

        S_INV_SQ: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= inv_b_r;
          mu_b_r     <= inv_b_r;
          mu_m_r     <= inv_m_r;
          mw_ret_r   <= S_INV_SQD;
          state_r    <= S_MW;
        end

        S_INV_SQD: begin
          inv_b_r <= mu_res;
          inv_e_r <= inv_e_r >> 1;
          if (inv_cnt_r == ecdsa_pkg::CNT_BITS'(W - 1)) begin
            state_r <= inv_ret_r;
          end else begin
            inv_cnt_r <= inv_cnt_r + 1'b1;
            state_r   <= S_INV_LP;
          end
        end

        // scalar multiply, MSB-first double-and-add: R = sc * B
        S_PM_ENT: begin
          rx_r     <= '0;
          ry_r     <= '0;
          rinf_r   <= 1'b1;
          pm_cnt_r <= ecdsa_pkg::CNT_BITS'(W - 1);
          state_r  <= S_PM_DBL;
        end

        S_PM_DBL: begin
          ax_r     <= rx_r;
          ay_r     <= ry_r;
          ainf_r   <= rinf_r;
          cx_r     <= rx_r;
          cy_r     <= ry_r;
          cinf_r   <= rinf_r;
          pa_ret_r <= S_PM_DBLD;
          state_r  <= S_PA_ENT;
        end

        S_PM_DBLD: begin
          if (sc_r[W-1]) begin
            ax_r     <= rx_r;
            ay_r     <= ry_r;
            ainf_r   <= rinf_r;
            cx_r     <= bx_r;
            cy_r     <= by_r;
            cinf_r   <= 1'b0;
            pa_ret_r <= S_PM_NXT;
            state_r  <= S_PA_ENT;
          end else begin
            state_r <= S_PM_NXT;
          end
        end

        S_PM_NXT: begin
          sc_r <= sc_r << 1;
          if (pm_cnt_r == '0) begin
            state_r <= pm_ret_r;
          end else begin
            pm_cnt_r <= pm_cnt_r - 1'b1;
            state_r  <= S_PM_DBL;
          end
        end

        // point add R = A + C (chord or tangent)
        S_PA_ENT: begin
          if (ainf_r) begin
            rx_r    <= cx_r;
            ry_r    <= cy_r;
            rinf_r  <= cinf_r;
            state_r <= pa_ret_r;
          end else if (cinf_r) begin
            rx_r    <= ax_r;
            ry_r    <= ay_r;
            rinf_r  <= 1'b0;
            state_r <= pa_ret_r;
          end else if (pts_differ) begin
            num_r   <= ecdsa_pkg::subm(cy_r, ay_r, cfg_p_r);
            den_r   <= ecdsa_pkg::subm(cx_r, ax_r, cfg_p_r);
            state_r <= S_PA_DEN;
          end else begin
            mu_start_r <= 1'b1;
            mu_op_r    <= ecdsa_pkg::ALU_MUL;
            mu_a_r     <= ax_r;
            mu_b_r     <= ax_r;
            mu_m_r     <= cfg_p_r;
            mw_ret_r   <= S_PA_T1;
            state_r    <= S_MW;
          end
        end

        S_PA_T1: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= c3_r;
          mu_b_r     <= mu_res;
          mu_m_r     <= cfg_p_r;
          mw_ret_r   <= S_PA_T2;
          state_r    <= S_MW;
        end

        S_PA_T2: begin
          num_r      <= ecdsa_pkg::addm(mu_res, ap_r, cfg_p_r);
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= c2_r;
          mu_b_r     <= ay_r;
          mu_m_r     <= cfg_p_r;
          mw_ret_r   <= S_PA_T3;
          state_r    <= S_MW;
        end

        S_PA_T3: begin
          den_r   <= mu_res;
          state_r <= S_PA_DEN;
        end

        S_PA_DEN: begin
          if (den_r == '0) begin
            rx_r    <= '0;
            ry_r    <= '0;
            rinf_r  <= 1'b1;
            state_r <= pa_ret_r;
          end else begin
            inv_a_r   <= den_r;
            inv_m_r   <= cfg_p_r;
            inv_ret_r <= S_PA_LAM;
            state_r   <= S_INV_ENT;
          end
        end

        S_PA_LAM: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= num_r;
          mu_b_r     <= inv_acc_r;
          mu_m_r     <= cfg_p_r;
          mw_ret_r   <= S_PA_L2;
          state_r    <= S_MW;
        end

        S_PA_L2: begin
          lam_r      <= mu_res;
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= mu_res;
          mu_b_r     <= mu_res;
          mu_m_r     <= cfg_p_r;
          mw_ret_r   <= S_PA_X;
          state_r    <= S_MW;
        end

        S_PA_X: begin
          x3_r    <= ecdsa_pkg::subm(ecdsa_pkg::subm(mu_res, ax_r, cfg_p_r), cx_r, cfg_p_r);
          state_r <= S_PA_Y1;
        end

        S_PA_Y1: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= lam_r;
          mu_b_r     <= ecdsa_pkg::subm(ax_r, x3_r, cfg_p_r);
          mu_m_r     <= cfg_p_r;
          mw_ret_r   <= S_PA_Y2;
          state_r    <= S_MW;
        end

        S_PA_Y2: begin
          rx_r    <= x3_r;
          ry_r    <= ecdsa_pkg::subm(mu_res, ay_r, cfg_p_r);
          rinf_r  <= 1'b0;
          state_r <= pa_ret_r;
        end

        // verify: w = s^-1, u1 = h*w, u2 = r*w, X = u1*G + u2*Q
        S_VF_U1: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= hq_r;
          mu_b_r     <= inv_acc_r;
          mu_m_r     <= cfg_q_r;
          mw_ret_r   <= S_VF_U2;
          state_r    <= S_MW;
        end

        S_VF_U2: begin
          u1_r       <= mu_res;
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= req_r.sig_r_in;
          mu_b_r     <= inv_acc_r;
          mu_m_r     <= cfg_q_r;
          mw_ret_r   <= S_VF_U3;
          state_r    <= S_MW;
        end

        S_VF_U3: begin
          u2_r     <= mu_res;
          bx_r     <= gx_r;
          by_r     <= gy_r;
          sc_r     <= u1_r;
          pm_ret_r <= S_VF_S;
          state_r  <= S_PM_ENT;
        end

        S_VF_S: begin
          sx_r     <= rx_r;
          sy_r     <= ry_r;
          sinf_r   <= rinf_r;
          bx_r     <= qx_r;
          by_r     <= qy_r;
          sc_r     <= u2_r;
          pm_ret_r <= S_VF_ADD;
          state_r  <= S_PM_ENT;
        end

        S_VF_ADD: begin
          ax_r     <= sx_r;
          ay_r     <= sy_r;
          ainf_r   <= sinf_r;
          cx_r     <= rx_r;
          cy_r     <= ry_r;
          cinf_r   <= rinf_r;
          pa_ret_r <= S_VF_CHK;
          state_r  <= S_PA_ENT;
        end

        S_VF_CHK: begin
          sr_r <= '0;
          ss_r <= '0;
          if (rinf_r) begin
            st_r    <= ecdsa_pkg::ST_INVALID;
            state_r <= S_FIN;
          end else begin
            mu_start_r <= 1'b1;
            mu_op_r    <= ecdsa_pkg::ALU_RED;
            mu_a_r     <= rx_r;
            mu_m_r     <= cfg_q_r;
            mw_ret_r   <= S_VF_CMP;
            state_r    <= S_MW;
          end
        end

        S_VF_CMP: begin
          st_r    <= (mu_res == req_r.sig_r_in) ? ecdsa_pkg::ST_VALID : ecdsa_pkg::ST_INVALID;
          state_r <= S_FIN;
        end

        // sign: r = x(kG) mod q, s = k^-1 (h + d r) mod q
        S_SG_R: begin
          sr_r <= '0;
          ss_r <= '0;
          st_r <= ecdsa_pkg::ST_REJECTED;
          if (rinf_r) begin
            state_r <= S_FIN;
          end else begin
            mu_start_r <= 1'b1;
            mu_op_r    <= ecdsa_pkg::ALU_RED;
            mu_a_r     <= rx_r;
            mu_m_r     <= cfg_q_r;
            mw_ret_r   <= S_SG_R2;
            state_r    <= S_MW;
          end
        end

        S_SG_R2: begin
          t_r <= mu_res;
          if (mu_res == '0) begin
            state_r <= S_FIN;
          end else begin
            mu_start_r <= 1'b1;
            mu_op_r    <= ecdsa_pkg::ALU_MUL;
            mu_a_r     <= dq_r;
            mu_b_r     <= mu_res;
            mu_m_r     <= cfg_q_r;
            mw_ret_r   <= S_SG_T;
            state_r    <= S_MW;
          end
        end

        S_SG_T: begin
          sr_r      <= t_r;
          t_r       <= ecdsa_pkg::addm(hq_r, mu_res, cfg_q_r);
          inv_a_r   <= kq_r;
          inv_m_r   <= cfg_q_r;
          inv_ret_r <= S_SG_S;
          state_r   <= S_INV_ENT;
        end

        S_SG_S: begin
          mu_start_r <= 1'b1;
          mu_op_r    <= ecdsa_pkg::ALU_MUL;
          mu_a_r     <= inv_acc_r;
          mu_b_r     <= t_r;
          mu_m_r     <= cfg_q_r;
          mw_ret_r   <= S_SG_S2;
          state_r    <= S_MW;
        end

        S_SG_S2: begin
          if (mu_res == '0) begin
            sr_r <= '0;
            ss_r <= '0;
          end else begin
            ss_r <= mu_res;
            st_r <= ecdsa_pkg::ST_SIGNED;
          end
          state_r <= S_FIN;
        end

        // hand the result to the output register once it is free
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_q_r     <= '{sig_r: sr_r, sig_s: ss_r, status: st_r};
            state_r     <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

endmodule

`default_nettype wire
